/* rtl/rbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and operation codes for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH      = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] data_in;
    } rbd_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              accepted;
        logic [OCC_W-1:0]  occupancy;
    } rbd_rsp_t;

    // Per-request status handed from the pointer logic to the result stage.
    typedef struct packed {
        logic             pop;
        logic             accepted;
        logic [OCC_W-1:0] occupancy;
    } rbd_stage_t;

endpackage

/* rtl/ring_buffer_deque.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue held in a power-of-two circular store.
// ----------------------------------------------------------------------------
// Each request pushes at the back or front, pops from the front or back, or
// flushes, and returns one response with the popped item, a success flag and
// the occupancy after the operation. One request is taken every clock while
// req_ready is high. The storage read is registered at the edge that accepts
// the request, and the response register loads from it once the result
// stage can advance. req_ready drops only while both result stages are full
// and rsp_ready is low. Storage is DEPTH words of ITEM_WIDTH bits; DEPTH
// must be a power of two.
module ring_buffer_deque #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rbd_pkg::rbd_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rbd_pkg::rbd_rsp_t rsp
);
    import rbd_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic             fire;
    logic             we;
    logic             re;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic [ITEM_WIDTH-1:0] rdata;
    rbd_stage_t       stage;
    logic             can_take;

    assign req_ready = can_take;
    assign fire      = req_valid && can_take;

    rbd_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .stage (stage)
    );

    rbd_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    rbd_out #(
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .stage     (stage),
        .rdata     (rdata),
        .can_take  (can_take),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* rtl/rbd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rbd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl
// Front and back pointers, full/empty decisions and storage access for
// each accepted request.
// ----------------------------------------------------------------------------
module rbd_ctrl #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  rbd_pkg::rbd_req_t        req,
    output logic                     we,
    output logic [$clog2(DEPTH)-1:0] waddr,
    output logic [ITEM_WIDTH-1:0]    wdata,
    output logic                     re,
    output logic [$clog2(DEPTH)-1:0] raddr,
    output rbd_pkg::rbd_stage_t      stage
);
    import rbd_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int PTR_W = IDX_W + 1;

    logic [PTR_W-1:0] back_reg, back_next;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] occ_now;
    logic [PTR_W-1:0] occ_after;
    logic [PTR_W+OCC_W-1:0] occ_ext;
    logic [ITEM_WIDTH+DATA_W-1:0] word_ext;
    logic full;
    logic empty;
    logic ok;
    logic pop;
    logic wr;
    logic rd;
    logic [PTR_W-1:0] back_dec;
    logic [PTR_W-1:0] front_dec;

    assign occ_now   = back_reg - front_reg;
    assign full      = (occ_now == PTR_W'(DEPTH));
    assign empty     = (occ_now == '0);
    assign back_dec  = back_reg - PTR_W'(1);
    assign front_dec = front_reg - PTR_W'(1);

    // The stored word keeps the low ITEM_WIDTH bits of the request data.
    assign word_ext = {{ITEM_WIDTH{1'b0}}, req.data_in};
    assign wdata    = word_ext[ITEM_WIDTH-1:0];

    always_comb
    begin
        back_next  = back_reg;
        front_next = front_reg;
        ok         = 1'b0;
        pop        = 1'b0;
        wr         = 1'b0;
        rd         = 1'b0;
        waddr      = back_reg[IDX_W-1:0];
        raddr      = front_reg[IDX_W-1:0];
        unique case (req.operation)
            OP_PUSH_BACK:
            begin
                ok        = !full;
                wr        = !full;
                waddr     = back_reg[IDX_W-1:0];
                back_next = full ? back_reg : back_reg + PTR_W'(1);
            end
            OP_PUSH_FRONT:
            begin
                ok         = !full;
                wr         = !full;
                waddr      = front_dec[IDX_W-1:0];
                front_next = full ? front_reg : front_dec;
            end
            OP_POP_FRONT:
            begin
                ok         = !empty;
                pop        = !empty;
                rd         = !empty;
                raddr      = front_reg[IDX_W-1:0];
                front_next = empty ? front_reg : front_reg + PTR_W'(1);
            end
            OP_POP_BACK:
            begin
                ok        = !empty;
                pop       = !empty;
                rd        = !empty;
                raddr     = back_dec[IDX_W-1:0];
                back_next = empty ? back_reg : back_dec;
            end
            OP_FLUSH:
            begin
                ok        = 1'b1;
                back_next = front_reg;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign occ_after = back_next - front_next;
    assign occ_ext   = {{OCC_W{1'b0}}, occ_after};

    assign we              = fire & wr;
    assign re              = fire & rd;
    assign stage.pop       = pop;
    assign stage.accepted  = ok;
    assign stage.occupancy = occ_ext[OCC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_reg  <= '0;
            front_reg <= '0;
        end
        else if (fire)
        begin
            back_reg  <= back_next;
            front_reg <= front_next;
        end
    end

endmodule

/* rtl/rbd_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_out
// Result pipeline: a stage that waits on the storage read, then the
// response register that faces the consumer.
// ----------------------------------------------------------------------------
module rbd_out #(
    parameter int ITEM_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  rbd_pkg::rbd_stage_t     stage,
    input  logic [ITEM_WIDTH-1:0]   rdata,
    output logic                    can_take,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output rbd_pkg::rbd_rsp_t       rsp
);
    import rbd_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    rbd_stage_t s1_info_reg;
    logic       out_valid_reg, out_valid_next;
    rbd_rsp_t   rsp_reg, rsp_next;
    logic       advance;
    logic [ITEM_WIDTH+DATA_W-1:0] rdata_ext;

    // The read data stays put in the RAM until the next pop is issued,
    // and a pop is only issued when this stage is free to move on.
    assign advance  = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign can_take = !s1_valid_reg || advance;

    assign rdata_ext = {{DATA_W{1'b0}}, rdata};

    always_comb
    begin
        s1_valid_next = fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);
        rsp_next.data_out  = s1_info_reg.pop ? rdata_ext[DATA_W-1:0] : '0;
        rsp_next.accepted  = s1_info_reg.accepted;
        rsp_next.occupancy = s1_info_reg.occupancy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_info_reg <= stage;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/rbd_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_check
// Port-level checks for the ring buffer deque, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_check #(
    parameter int DEPTH = 16
) (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input rbd_pkg::rbd_req_t req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input rbd_pkg::rbd_rsp_t rsp
);
    import rbd_pkg::*;

    // A refused response never carries data.
    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.accepted |-> rsp.data_out == '0)
        else $error("refused request returned nonzero data");

    // The reported occupancy never exceeds the capacity.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.occupancy) <= 32'(DEPTH))
        else $error("occupancy above capacity");

    // Requests are only held off while a response waits on the consumer.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled with no pending response");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

endmodule

bind ring_buffer_deque rbd_check #(.DEPTH(DEPTH)) u_check (.*);
